/* hdl/bbc_pkg.sv */
// Shared types and constants of the buffer cache tag and policy engine.
`default_nettype none
package bbc_pkg;

    localparam int ENTRIES_DEFAULT = 64;
    localparam int CNT_W           = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_FILLED    = 3'd1;
    localparam logic [2:0] ST_ZERO      = 3'd2;
    localparam logic [2:0] ST_NONE      = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;
    localparam logic [2:0] ST_HELD      = 3'd5;
    localparam logic [2:0] ST_RELEASED  = 3'd6;
    localparam logic [2:0] ST_BADPUT    = 3'd7;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // what a probe looks for as it walks the chain
    typedef enum logic [1:0] {
        MODE_TAG = 2'd0,
        MODE_LRU = 2'd1,
        MODE_IDX = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CMD_NOP  = 2'd0,
        CMD_HIT  = 2'd1,
        CMD_FILL = 2'd2,
        CMD_PUT  = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    unlist;
    } cmd_t;

endpackage
`default_nettype wire

/* hdl/bbc_cell.sv */
// One cache entry: tags, count and release rank, plus one stage of the probe chain.
`default_nettype none
module bbc_cell
    import bbc_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEFAULT,
    parameter int CELL_IDX = 0,
    localparam int IW = $clog2(ENTRIES),
    localparam int CW = $clog2(ENTRIES + 1)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             p_in_v,
    input  wire logic             p_in_found,
    input  wire logic [IW-1:0]    p_in_idx,
    input  wire logic             p_in_valid,
    input  wire logic [CNT_W-1:0] p_in_cnt,
    input  wire logic [CW-1:0]    p_in_rank,
    output logic                  p_out_v,
    output logic                  p_out_found,
    output logic [IW-1:0]         p_out_idx,
    output logic                  p_out_valid,
    output logic [CNT_W-1:0]      p_out_cnt,
    output logic [CW-1:0]         p_out_rank,
    input  wire mode_t            mode,
    input  wire logic [31:0]      key_inode,
    input  wire logic [31:0]      key_index,
    input  wire logic [5:0]       key_rel,
    input  wire cmd_t             cmd,
    input  wire logic [IW-1:0]    cmd_idx,
    input  wire logic [CW-1:0]    unlist_rank,
    input  wire logic [CW-1:0]    put_rank
);

    logic             valid_reg, valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]    rank_reg, rank_next;
    logic [31:0]      ino_reg, ino_next;
    logic [31:0]      idx_reg, idx_next;

    logic             pv_reg, pfound_reg, pvalid_reg;
    logic [IW-1:0]    pidx_reg;
    logic [CNT_W-1:0] pcnt_reg;
    logic [CW-1:0]    prank_reg;

    logic sel, listed, match;

    always_comb
    begin
        sel    = (cmd.op != CMD_NOP) && (cmd_idx == IW'(CELL_IDX));
        listed = valid_reg && (cnt_reg == '0);
        case (mode)
            MODE_TAG: match = valid_reg && (ino_reg == key_inode) && (idx_reg == key_index);
            MODE_LRU: match = listed && (rank_reg == '0);
            MODE_IDX: match = (32'(key_rel) == 32'(CELL_IDX));
            default:  match = 1'b0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        rank_next  = rank_reg;
        ino_next   = ino_reg;
        idx_next   = idx_reg;
        // close the gap left by an entry leaving the release list
        if (cmd.unlist && !sel && listed && (rank_reg > unlist_rank))
        begin
            rank_next = rank_reg - CW'(1);
        end
        if (sel)
        begin
            case (cmd.op)
                CMD_HIT:
                begin
                    if (cnt_reg != CNT_MAX)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                CMD_FILL:
                begin
                    valid_next = 1'b1;
                    cnt_next   = CNT_W'(1);
                    ino_next   = key_inode;
                    idx_next   = key_index;
                end
                CMD_PUT:
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        rank_next = put_rank;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= p_in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg <= rank_next;
        ino_reg  <= ino_next;
        idx_reg  <= idx_next;
        // first match along the chain wins
        if (p_in_found || !match)
        begin
            pfound_reg <= p_in_found;
            pidx_reg   <= p_in_idx;
            pvalid_reg <= p_in_valid;
            pcnt_reg   <= p_in_cnt;
            prank_reg  <= p_in_rank;
        end
        else
        begin
            pfound_reg <= 1'b1;
            pidx_reg   <= IW'(CELL_IDX);
            pvalid_reg <= valid_reg;
            pcnt_reg   <= cnt_reg;
            prank_reg  <= rank_reg;
        end
    end

    assign p_out_v     = pv_reg;
    assign p_out_found = pfound_reg;
    assign p_out_idx   = pidx_reg;
    assign p_out_valid = pvalid_reg;
    assign p_out_cnt   = pcnt_reg;
    assign p_out_rank  = prank_reg;

endmodule
`default_nettype wire

/* hdl/block_buffer_cache_lru.sv */
// Top level of the buffer cache tag and policy engine: request control and the cell chain.
//
//  channel | signals                  | carries
//  --------+--------------------------+-----------------------------------------------
//  in      | in_valid / in_ready      | operation, file_inode, block_index, ...
//  out     | out_valid / out_ready    | status, entry_number, fetch_address
//
// A probe walks the chain one cell per cycle; a hit, miss or put walks it once, while a fill
// that recycles the least recently released entry walks it a second time to find that entry.
// Reset clears valid bits, counts and control; tags and ranks load on first use.
// A finished result sits in the output register; the next request is accepted meanwhile
// and only its completion waits for that register to drain.
`default_nettype none
module block_buffer_cache_lru
    import bbc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [31:0] file_inode,
    input  wire logic [31:0] block_index,
    input  wire logic [31:0] block_address,
    input  wire logic        translate_failed,
    input  wire logic [5:0]  release_entry,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [5:0]       entry_number,
    output logic [31:0]      fetch_address
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic   start_reg, start_next;
    logic [CW-1:0] rel_cnt_reg, rel_cnt_next;
    logic [CW-1:0] unused_reg, unused_next;

    logic        tfail_reg;
    logic [31:0] ino_reg, idx_reg, addr_reg;
    logic [5:0]  rel_reg;

    logic             res_found_reg, res_valid_reg;
    logic [IW-1:0]    res_idx_reg;
    logic [CNT_W-1:0] res_cnt_reg;
    logic [CW-1:0]    res_rank_reg;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [5:0]  entry_reg, entry_next;
    logic [31:0] fetch_reg, fetch_next;

    cmd_t          cmd;
    logic [IW-1:0] cmd_idx;
    logic [CW-1:0] unlist_rank;

    logic             link_v     [ENTRIES+1];
    logic             link_found [ENTRIES+1];
    logic [IW-1:0]    link_idx   [ENTRIES+1];
    logic             link_valid [ENTRIES+1];
    logic [CNT_W-1:0] link_cnt   [ENTRIES+1];
    logic [CW-1:0]    link_rank  [ENTRIES+1];

    logic accept, drain_ok;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign drain_ok = !out_valid_reg || out_ready;

    assign link_v[0]     = start_reg;
    assign link_found[0] = 1'b0;
    assign link_idx[0]   = '0;
    assign link_valid[0] = 1'b0;
    assign link_cnt[0]   = '0;
    assign link_rank[0]  = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        bbc_cell #(
            .ENTRIES  (ENTRIES),
            .CELL_IDX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .p_in_v      (link_v[i]),
            .p_in_found  (link_found[i]),
            .p_in_idx    (link_idx[i]),
            .p_in_valid  (link_valid[i]),
            .p_in_cnt    (link_cnt[i]),
            .p_in_rank   (link_rank[i]),
            .p_out_v     (link_v[i+1]),
            .p_out_found (link_found[i+1]),
            .p_out_idx   (link_idx[i+1]),
            .p_out_valid (link_valid[i+1]),
            .p_out_cnt   (link_cnt[i+1]),
            .p_out_rank  (link_rank[i+1]),
            .mode        (mode_reg),
            .key_inode   (ino_reg),
            .key_index   (idx_reg),
            .key_rel     (rel_reg),
            .cmd         (cmd),
            .cmd_idx     (cmd_idx),
            .unlist_rank (unlist_rank),
            .put_rank    (rel_cnt_reg)
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        start_next     = 1'b0;
        rel_cnt_next   = rel_cnt_reg;
        unused_next    = unused_reg;
        cmd            = '{op: CMD_NOP, unlist: 1'b0};
        cmd_idx        = res_idx_reg;
        unlist_rank    = res_rank_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        entry_next     = entry_reg;
        fetch_next     = fetch_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                    start_next = 1'b1;
                    mode_next  = (operation == OP_PUT) ? MODE_IDX : MODE_TAG;
                end
            end
            S_SCAN:
            begin
                if (link_v[ENTRIES])
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (drain_ok)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    entry_next     = '0;
                    fetch_next     = '0;
                    case (mode_reg)
                        MODE_IDX:
                        begin
                            if (!res_found_reg || !res_valid_reg || res_cnt_reg == '0)
                            begin
                                status_next = ST_BADPUT;
                            end
                            else
                            begin
                                cmd.op = CMD_PUT;
                                if (res_cnt_reg == CNT_W'(1))
                                begin
                                    status_next  = ST_RELEASED;
                                    rel_cnt_next = rel_cnt_reg + CW'(1);
                                end
                                else
                                begin
                                    status_next = ST_HELD;
                                end
                            end
                        end
                        MODE_TAG:
                        begin
                            if (res_found_reg)
                            begin
                                cmd.op      = CMD_HIT;
                                cmd.unlist  = (res_cnt_reg == '0);
                                status_next = ST_HIT;
                                entry_next  = 6'(res_idx_reg);
                                if (res_cnt_reg == '0 && rel_cnt_reg != '0)
                                begin
                                    rel_cnt_next = rel_cnt_reg - CW'(1);
                                end
                            end
                            else if (tfail_reg)
                            begin
                                status_next = ST_NONE;
                            end
                            else if (addr_reg == '0)
                            begin
                                status_next = ST_ZERO;
                            end
                            else if (unused_reg < CW'(ENTRIES))
                            begin
                                cmd.op      = CMD_FILL;
                                cmd_idx     = unused_reg[IW-1:0];
                                unused_next = unused_reg + CW'(1);
                                status_next = ST_FILLED;
                                entry_next  = 6'(unused_reg[IW-1:0]);
                                fetch_next  = addr_reg;
                            end
                            else if (rel_cnt_reg != '0)
                            begin
                                // second pass: find the oldest released entry
                                state_next     = S_SCAN;
                                start_next     = 1'b1;
                                mode_next      = MODE_LRU;
                                out_valid_next = out_valid_reg && !out_ready;
                                entry_next     = entry_reg;
                                fetch_next     = fetch_reg;
                            end
                            else
                            begin
                                status_next = ST_EXHAUSTED;
                            end
                        end
                        MODE_LRU:
                        begin
                            if (res_found_reg)
                            begin
                                cmd.op       = CMD_FILL;
                                cmd.unlist   = 1'b1;
                                unlist_rank  = '0;
                                rel_cnt_next = rel_cnt_reg - CW'(1);
                                status_next  = ST_FILLED;
                                entry_next   = 6'(res_idx_reg);
                                fetch_next   = addr_reg;
                            end
                            else
                            begin
                                status_next = ST_EXHAUSTED;
                            end
                        end
                        default:
                        begin
                            status_next = ST_EXHAUSTED;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_TAG;
            start_reg     <= 1'b0;
            rel_cnt_reg   <= '0;
            unused_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            start_reg     <= start_next;
            rel_cnt_reg   <= rel_cnt_next;
            unused_reg    <= unused_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ino_reg   <= file_inode;
            idx_reg   <= block_index;
            addr_reg  <= block_address;
            tfail_reg <= translate_failed;
            rel_reg   <= release_entry;
        end
        if (state_reg == S_SCAN && link_v[ENTRIES])
        begin
            res_found_reg <= link_found[ENTRIES];
            res_idx_reg   <= link_idx[ENTRIES];
            res_valid_reg <= link_valid[ENTRIES];
            res_cnt_reg   <= link_cnt[ENTRIES];
            res_rank_reg  <= link_rank[ENTRIES];
        end
        status_reg <= status_next;
        entry_reg  <= entry_next;
        fetch_reg  <= fetch_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign entry_number  = entry_reg;
    assign fetch_address = fetch_reg;

endmodule
`default_nettype wire
